// ===== src/noise_lfsr_channel_macros.svh =====
// ----------------------------------------------------------------------------
// noise_lfsr_channel assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef NOISE_LFSR_CHANNEL_MACROS_SVH
`define NOISE_LFSR_CHANNEL_MACROS_SVH

`ifndef SYNTHESIS

// checked only out of reset
`define NLC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// checked on every edge, reset included
`define NLC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define NLC_ASSERT(lbl, clk, rstn, prop, msg)
`define NLC_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== src/nlc_pkg.sv =====
// ----------------------------------------------------------------------------
// nlc_pkg
// Shared types and constants of the noise LFSR channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package nlc_pkg;

    localparam int LFSR_W = 15;

    localparam logic [LFSR_W-1:0] TAP_LONG   = 15'h6000;
    localparam logic [LFSR_W-1:0] TAP_SHORT  = 15'h0060;
    localparam logic [LFSR_W-1:0] SEED_LONG  = 15'h4000;
    localparam logic [LFSR_W-1:0] SEED_SHORT = 15'h0040;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    localparam logic [2:0] OFF_LEN  = 3'd0;
    localparam logic [2:0] OFF_ENV  = 3'd1;
    localparam logic [2:0] OFF_CTRL = 3'd4;
    localparam logic [2:0] OFF_TRIG = 3'd5;

    // control from the sequencer to the shift unit
    typedef struct packed {
        logic shift;
        logic seed;
        logic short_mode;
    } lfsr_ctl_t;

endpackage

`default_nettype wire

// ===== src/nlc_lfsr.sv =====
// ----------------------------------------------------------------------------
// nlc_lfsr
// 15-bit Galois shift unit: one shift or one seed load per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nlc_lfsr (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire nlc_pkg::lfsr_ctl_t ctl,
    output logic                   out_bit
);
    import nlc_pkg::*;

    logic [LFSR_W-1:0] lfsr_reg;
    logic [LFSR_W-1:0] lfsr_next;
    logic [LFSR_W-1:0] tap;

    assign out_bit = lfsr_reg[0];
    assign tap     = ctl.short_mode ? TAP_SHORT : TAP_LONG;

    always_comb begin
        lfsr_next = lfsr_reg;
        if (ctl.seed) begin
            lfsr_next = ctl.short_mode ? SEED_SHORT : SEED_LONG;
        end else if (ctl.shift) begin
            lfsr_next = (lfsr_reg >> 1) ^ (lfsr_reg[0] ? tap : '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lfsr_reg <= '0;
        end else begin
            lfsr_reg <= lfsr_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/noise_lfsr_channel.sv =====
// ----------------------------------------------------------------------------
// noise_lfsr_channel
// Noise channel register bank and tick sequencer around a single shift unit.
// ----------------------------------------------------------------------------
// channel | dir | tdata / tuser
// s_      | in  | request: tuser op, tdata offset/write_data/volume/on/extra
// m_      | out | result: read_data, sample, length and status fields
//
// Read, write, op 3 or tick with channel off: accept goes straight to the final state, which registers the result.
// Tick with channel on: first-step state, min(extra_steps, MAX_EXTRA) extra steps, final state; the shift
// unit does one LFSR step per cycle, sample on the first step.
// Reset clears LFSR, envelope, control and length enable.
// s_tready is high only while no request is in work; a result waiting on
// m_tready holds the sequencer in its final state.
`timescale 1ns / 1ps
`default_nettype none
`include "noise_lfsr_channel_macros.svh"

module noise_lfsr_channel #(
    parameter int MAX_EXTRA = 255
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [2:0] offset, [10:3] write_data, [14:11] volume, [15] channel_on,
    // [23:16] extra_steps
    input  wire logic [23:0] s_tdata,
    // [1:0] op
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [7:0] read_data, [15:8] sample, [22:16] length_reload, [23] length_enable,
    // [24] stop_channel, [25] restart_channel, [33:26] envelope_setting,
    // [36:34] rate_ratio, [40:37] rate_shift, [47:41] zero
    output logic [47:0]      m_tdata
);
    import nlc_pkg::*;

    localparam int EFF_MAX = (MAX_EXTRA < 255) ? MAX_EXTRA : 255;
    localparam int CNT_W   = (EFF_MAX > 0) ? $clog2(EFF_MAX + 1) : 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FIRST = 2'd1;
    localparam logic [1:0] ST_EXTRA = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0]       env_reg, env_next;
    logic [7:0]       ctrl_reg, ctrl_next;
    logic             len_reg, len_next;
    logic [3:0]       vol_reg, vol_next;
    logic [7:0]       rd_reg, rd_next;
    logic [7:0]       smp_reg, smp_next;
    logic [6:0]       reload_reg, reload_next;
    logic             stop_reg, stop_next;
    logic             restart_reg, restart_next;
    logic             m_valid_reg, m_valid_next;
    logic [47:0]      m_data_reg, m_data_next;

    logic [2:0]       in_offset;
    logic [7:0]       in_data;
    logic [3:0]       in_volume;
    logic             in_on;
    logic [7:0]       in_extra;
    logic             accept;
    logic             out_free;
    logic             dac_on;
    logic [CNT_W-1:0] steps;
    logic [7:0]       mag;
    lfsr_ctl_t        lfsr_ctl;
    logic             lfsr_bit;

    assign in_offset = s_tdata[2:0];
    assign in_data   = s_tdata[10:3];
    assign in_volume = s_tdata[14:11];
    assign in_on     = s_tdata[15];
    assign in_extra  = s_tdata[23:16];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign dac_on   = |env_reg[7:3];
    assign mag      = {1'b0, vol_reg, 3'b000};
    assign steps    = (32'(in_extra) > 32'(MAX_EXTRA)) ? CNT_W'(EFF_MAX) : CNT_W'(in_extra);

    nlc_lfsr u_lfsr (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (lfsr_ctl),
        .out_bit (lfsr_bit)
    );

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        env_next       = env_reg;
        ctrl_next      = ctrl_reg;
        len_next       = len_reg;
        vol_next       = vol_reg;
        rd_next        = rd_reg;
        smp_next       = smp_reg;
        reload_next    = reload_reg;
        stop_next      = stop_reg;
        restart_next   = restart_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_data_next    = m_data_reg;
        lfsr_ctl       = '0;
        lfsr_ctl.short_mode = ctrl_reg[3];

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    rd_next      = '0;
                    smp_next     = '0;
                    reload_next  = '0;
                    stop_next    = 1'b0;
                    restart_next = 1'b0;
                    state_next   = ST_DONE;
                    unique case (s_tuser)
                        OP_READ: begin
                            unique case (in_offset)
                                OFF_ENV:  rd_next = env_reg;
                                OFF_CTRL: rd_next = ctrl_reg;
                                OFF_TRIG: rd_next = {1'b0, len_reg, 6'd0};
                                default:  rd_next = '0;
                            endcase
                        end
                        OP_WRITE: begin
                            unique case (in_offset)
                                OFF_LEN: begin
                                    reload_next = 7'd64 - {1'b0, in_data[5:0]};
                                end
                                OFF_ENV: begin
                                    env_next  = in_data;
                                    stop_next = ~|in_data[7:3];
                                end
                                OFF_CTRL: begin
                                    ctrl_next = in_data;
                                end
                                OFF_TRIG: begin
                                    len_next = in_data[6];
                                    if (dac_on && in_data[7]) begin
                                        lfsr_ctl.seed = 1'b1;
                                        restart_next  = 1'b1;
                                    end
                                end
                                default: begin
                                end
                            endcase
                        end
                        OP_TICK: begin
                            if (in_on) begin
                                vol_next   = in_volume;
                                cnt_next   = steps;
                                state_next = ST_FIRST;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FIRST: begin
                lfsr_ctl.shift = 1'b1;
                if (!dac_on) begin
                    smp_next = '0;
                end else begin
                    smp_next = lfsr_bit ? mag : 8'd0 - mag;
                end
                state_next = (cnt_reg == '0) ? ST_DONE : ST_EXTRA;
            end
            ST_EXTRA: begin
                lfsr_ctl.shift = 1'b1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {7'd0, ctrl_reg[7:4], ctrl_reg[2:0], env_reg,
                                    restart_reg, stop_reg, len_reg, reload_reg,
                                    smp_reg, rd_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            env_reg     <= '0;
            ctrl_reg    <= '0;
            len_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            env_reg     <= env_next;
            ctrl_reg    <= ctrl_next;
            len_reg     <= len_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        vol_reg     <= vol_next;
        rd_reg      <= rd_next;
        smp_reg     <= smp_next;
        reload_reg  <= reload_next;
        stop_reg    <= stop_next;
        restart_reg <= restart_next;
        m_data_reg  <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `NLC_ASSERT(a_busy_after_req, aclk, aresetn, accept |=> !s_tready, "ready after request")
    `NLC_ASSERT(a_extra_nonzero, aclk, aresetn, (state_reg == ST_EXTRA) |-> (cnt_reg != '0), "extra shift with zero count")
    `NLC_ASSERT(a_publish, aclk, aresetn, (state_reg == ST_DONE && out_free) |=> (m_tvalid && s_tready), "result not published")
    `NLC_ASSERT_ALWAYS(a_reset_clear, aclk, !aresetn |=> (!m_tvalid && s_tready), "reset did not clear control")

endmodule

`default_nettype wire

// ===== tb/noise_lfsr_channel_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// noise_lfsr_channel_tb
// Self-checking bench for the noise channel: register reads and writes,
// triggers and LFSR ticks in long and short mode, checked per field against
// an in-bench channel predictor under random stalls on both streams.
// ----------------------------------------------------------------------------

module noise_lfsr_channel_tb;
    import nlc_pkg::*;

    localparam int MAX_EXTRA    = 255;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 300;
    localparam logic [1:0] OP_NONE = 2'd3;

    // request fields, lowest first: offset, write_data, volume, on, extra
    typedef struct packed {
        logic [7:0] extra_steps;
        logic       channel_on;
        logic [3:0] volume;
        logic [7:0] write_data;
        logic [2:0] offset;
    } chan_request_t;

    typedef struct packed {
        logic [6:0]        pad;
        logic [3:0]        rate_shift;
        logic [2:0]        rate_ratio;
        logic [7:0]        envelope_setting;
        logic              restart_channel;
        logic              stop_channel;
        logic              length_enable;
        logic [6:0]        length_reload;
        logic signed [7:0] sample;
        logic [7:0]        read_data;
    } chan_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;

    always #5 aclk = ~aclk;

    noise_lfsr_channel #(
        .MAX_EXTRA(MAX_EXTRA)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // predicted channel state
    logic [LFSR_W-1:0] noise_lfsr = '0;
    logic [7:0]        env_reg    = '0;
    logic [7:0]        ctrl_reg   = '0;
    logic              len_en_reg = 1'b0;

    chan_result_t expected_results[$];

    bit gaps_on = 1'b1;
    int stall_left = 0;
    int quiet_cycles = 0;
    int error_count = 0;
    int results_checked = 0;
    int ticks_sent = 0;
    int writes_sent = 0;
    int reads_sent = 0;
    int restarts_seen = 0;
    int stops_seen = 0;

    function automatic logic advance_lfsr();
        logic dropped;
        dropped = noise_lfsr[0];
        noise_lfsr = noise_lfsr >> 1;
        if (dropped) begin
            noise_lfsr = noise_lfsr ^ (ctrl_reg[3] ? TAP_SHORT : TAP_LONG);
        end
        return dropped;
    endfunction

    function automatic chan_result_t predict_channel(logic [1:0] op, chan_request_t req);
        chan_result_t res;
        logic         dropped;
        int           level;
        int           steps;
        res = '0;
        case (op)
            OP_READ: begin
                case (req.offset)
                    OFF_ENV:  res.read_data = env_reg;
                    OFF_CTRL: res.read_data = ctrl_reg;
                    OFF_TRIG: res.read_data = len_en_reg ? 8'h40 : 8'h00;
                    default:  res.read_data = 8'h00;
                endcase
            end
            OP_WRITE: begin
                case (req.offset)
                    OFF_LEN: begin
                        res.length_reload = 7'd64 - {1'b0, req.write_data[5:0]};
                    end
                    OFF_ENV: begin
                        env_reg = req.write_data;
                        res.stop_channel = (env_reg[7:3] == 5'd0);
                    end
                    OFF_CTRL: begin
                        ctrl_reg = req.write_data;
                    end
                    OFF_TRIG: begin
                        len_en_reg = req.write_data[6];
                        if (env_reg[7:3] != 5'd0 && req.write_data[7]) begin
                            noise_lfsr = ctrl_reg[3] ? SEED_SHORT : SEED_LONG;
                            res.restart_channel = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            OP_TICK: begin
                if (req.channel_on) begin
                    dropped = advance_lfsr();
                    level = 8 * int'(req.volume);
                    if (!dropped) begin
                        level = -level;
                    end
                    if (env_reg[7:3] == 5'd0) begin
                        level = 0;
                    end
                    res.sample = level[7:0];
                    steps = (int'(req.extra_steps) > MAX_EXTRA) ? MAX_EXTRA
                                                                : int'(req.extra_steps);
                    repeat (steps) void'(advance_lfsr());
                end
            end
            default: ;
        endcase
        res.length_enable    = len_en_reg;
        res.envelope_setting = env_reg;
        res.rate_ratio       = ctrl_reg[2:0];
        res.rate_shift       = ctrl_reg[7:4];
        return res;
    endfunction

    function automatic chan_request_t make_request(logic [2:0] offset, logic [7:0] data,
                                                   logic [3:0] vol, logic on,
                                                   logic [7:0] extra);
        chan_request_t req;
        req.offset      = offset;
        req.write_data  = data;
        req.volume      = vol;
        req.channel_on  = on;
        req.extra_steps = extra;
        return req;
    endfunction

    // valid stays high between back-to-back requests; it only drops for a gap
    task automatic send_request(logic [1:0] op, chan_request_t req);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= req;
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_results.push_back(predict_channel(op, req));
        case (op)
            OP_TICK:  ticks_sent++;
            OP_WRITE: writes_sent++;
            OP_READ:  reads_sent++;
            default: ;
        endcase
    endtask

    task automatic check_result(chan_result_t exp, chan_result_t got);
        results_checked++;
        if (got.restart_channel) restarts_seen++;
        if (got.stop_channel) stops_seen++;
        if (got.read_data !== exp.read_data) begin
            $error("read_data: expected %0h, got %0h", exp.read_data, got.read_data);
            error_count++;
        end
        if (got.sample !== exp.sample) begin
            $error("sample: expected %0d, got %0d", exp.sample, got.sample);
            error_count++;
        end
        if (got.length_reload !== exp.length_reload) begin
            $error("length_reload: expected %0d, got %0d",
                   exp.length_reload, got.length_reload);
            error_count++;
        end
        if (got.length_enable !== exp.length_enable) begin
            $error("length_enable: expected %0b, got %0b",
                   exp.length_enable, got.length_enable);
            error_count++;
        end
        if (got.stop_channel !== exp.stop_channel) begin
            $error("stop_channel: expected %0b, got %0b", exp.stop_channel, got.stop_channel);
            error_count++;
        end
        if (got.restart_channel !== exp.restart_channel) begin
            $error("restart_channel: expected %0b, got %0b",
                   exp.restart_channel, got.restart_channel);
            error_count++;
        end
        if (got.envelope_setting !== exp.envelope_setting) begin
            $error("envelope_setting: expected %0h, got %0h",
                   exp.envelope_setting, got.envelope_setting);
            error_count++;
        end
        if (got.rate_ratio !== exp.rate_ratio) begin
            $error("rate_ratio: expected %0d, got %0d", exp.rate_ratio, got.rate_ratio);
            error_count++;
        end
        if (got.rate_shift !== exp.rate_shift) begin
            $error("rate_shift: expected %0d, got %0d", exp.rate_shift, got.rate_shift);
            error_count++;
        end
    endtask

    // result sink with random stall bursts
    always @(posedge aclk) begin
        if (gaps_on && stall_left == 0 && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 12);
        end
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $error("result with no request outstanding: %h", m_tdata);
                error_count++;
            end else begin
                check_result(expected_results.pop_front(), chan_result_t'(m_tdata));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $error("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic test_reset_state();
        send_request(OP_READ, make_request(OFF_LEN, 8'h00, 4'h0, 1'b0, 8'h00));
        send_request(OP_READ, make_request(OFF_ENV, 8'hFF, 4'hF, 1'b1, 8'hFF));
        send_request(OP_READ, make_request(OFF_TRIG, 8'h00, 4'h0, 1'b0, 8'h00));
        // all-zero LFSR stays zero, DAC still off
        send_request(OP_TICK, make_request(3'd0, 8'h00, 4'hF, 1'b1, 8'h03));
    endtask

    task automatic test_register_writes();
        send_request(OP_WRITE, make_request(OFF_LEN, 8'h00, 4'h0, 1'b0, 8'h00));
        send_request(OP_WRITE, make_request(OFF_LEN, 8'hFF, 4'h0, 1'b0, 8'h00));
        send_request(OP_WRITE, make_request(OFF_ENV, 8'h07, 4'h0, 1'b0, 8'h00));
        send_request(OP_WRITE, make_request(OFF_ENV, 8'hF8, 4'h0, 1'b0, 8'h00));
        send_request(OP_WRITE, make_request(OFF_CTRL, 8'hFF, 4'h0, 1'b0, 8'h00));
        send_request(OP_WRITE, make_request(3'd3, 8'hFF, 4'hF, 1'b1, 8'hFF));
        send_request(OP_NONE, make_request(OFF_TRIG, 8'hFF, 4'hF, 1'b1, 8'hFF));
        send_request(OP_READ, make_request(OFF_CTRL, 8'h00, 4'h0, 1'b0, 8'h00));
    endtask

    task automatic test_lfsr_modes();
        // trigger with the DAC off only sets the length enable
        send_request(OP_WRITE, make_request(OFF_ENV, 8'h00, 4'h0, 1'b0, 8'h00));
        send_request(OP_WRITE, make_request(OFF_TRIG, 8'hC0, 4'h0, 1'b0, 8'h00));
        send_request(OP_WRITE, make_request(OFF_ENV, 8'hF0, 4'h0, 1'b0, 8'h00));
        send_request(OP_WRITE, make_request(OFF_CTRL, 8'h00, 4'h0, 1'b0, 8'h00));
        send_request(OP_WRITE, make_request(OFF_TRIG, 8'h80, 4'h0, 1'b0, 8'h00));
        send_request(OP_TICK, make_request(3'd0, 8'h00, 4'hF, 1'b1, 8'h00));
        send_request(OP_TICK, make_request(3'd0, 8'h00, 4'hF, 1'b1, 8'hFF));
        send_request(OP_TICK, make_request(3'd0, 8'h00, 4'hF, 1'b0, 8'hFF));
        send_request(OP_WRITE, make_request(OFF_CTRL, 8'h08, 4'h0, 1'b0, 8'h00));
        send_request(OP_WRITE, make_request(OFF_TRIG, 8'hC0, 4'h0, 1'b0, 8'h00));
        send_request(OP_TICK, make_request(3'd0, 8'h00, 4'h0, 1'b1, 8'h01));
        send_request(OP_TICK, make_request(3'd0, 8'h00, 4'h8, 1'b1, 8'h05));
        send_request(OP_WRITE, make_request(OFF_ENV, 8'h00, 4'h0, 1'b0, 8'h00));
        send_request(OP_TICK, make_request(3'd0, 8'h00, 4'hF, 1'b1, 8'h02));
    endtask

    task automatic send_random_requests(int count);
        chan_request_t req;
        logic [1:0]    op;
        int            pick;
        repeat (count) begin
            req.offset      = 3'($urandom_range(0, 7));
            req.write_data  = 8'($urandom_range(0, 255));
            req.volume      = 4'($urandom_range(0, 15));
            req.channel_on  = ($urandom_range(0, 7) != 0);
            req.extra_steps = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                          : 8'($urandom_range(0, 15));
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                op = OP_TICK;
            end else if (pick < 80) begin
                op = OP_WRITE;
                case ($urandom_range(0, 9))
                    0, 1, 2: req.offset = OFF_TRIG;
                    3, 4:    req.offset = OFF_ENV;
                    5, 6:    req.offset = OFF_CTRL;
                    7:       req.offset = OFF_LEN;
                    default: ;
                endcase
                // now and then turn the DAC off
                if (req.offset == OFF_ENV && $urandom_range(0, 7) == 0) begin
                    req.write_data[7:3] = 5'd0;
                end
            end else if (pick < 96) begin
                op = OP_READ;
            end else begin
                op = OP_NONE;
            end
            send_request(op, req);
        end
    endtask

    task automatic test_random_traffic(int blocks);
        repeat (blocks) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            send_random_requests(100);
        end
    endtask

    task automatic test_back_to_back(int count);
        gaps_on = 1'b0;
        send_random_requests(count);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_state();
        test_register_writes();
        test_lfsr_modes();
        test_random_traffic(14);
        test_back_to_back(280);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Covered %0d ticks, %0d writes, %0d reads; %0d results checked",
                 ticks_sent, writes_sent, reads_sent, results_checked);
        $display("Observed %0d restarts and %0d DAC-off stops, %0d mismatches",
                 restarts_seen, stops_seen, error_count);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== noise_lfsr_channel.f =====
+incdir+src
src/nlc_pkg.sv
src/nlc_lfsr.sv
src/noise_lfsr_channel.sv
tb/noise_lfsr_channel_tb.sv
